// ----- sv/i2cm_pkg.sv -----
// shared types, phase codes, command codes and register constants of the i2c bit engine
package i2cm_pkg;

    // phase codes of the bit engine
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_HI   = 4'd1;
    localparam logic [3:0] PH_ST_LO   = 4'd2;
    localparam logic [3:0] PH_SP_LO   = 4'd3;
    localparam logic [3:0] PH_SP_HI   = 4'd4;
    localparam logic [3:0] PH_WR_LO   = 4'd5;
    localparam logic [3:0] PH_WR_HI   = 4'd6;
    localparam logic [3:0] PH_AK_LO   = 4'd7;
    localparam logic [3:0] PH_AK_HI   = 4'd8;
    localparam logic [3:0] PH_AK_WAIT = 4'd9;
    localparam logic [3:0] PH_RD_LO   = 4'd10;
    localparam logic [3:0] PH_RD_HI   = 4'd11;
    localparam logic [3:0] PH_RA_LO   = 4'd12;
    localparam logic [3:0] PH_RA_HI   = 4'd13;

    // command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // register indexes and reset values
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // configuration seen by the engine
    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [7:0] ack_timeout;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_result;

endpackage

// ----- sv/i2cm_in_if.sv -----
// request channel carrying one tick of commands and the sampled sda level
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, output cmd, output tx_byte, output send_ack,
                    output sda_in, input ready);
    modport sink   (input valid, input cmd, input tx_byte, input send_ack,
                    input sda_in, output ready);
endinterface

// ----- sv/i2cm_out_if.sv -----
// result channel carrying the line levels and status after each tick
interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;

    modport source (output valid, output scl_level, output sda_level, output sda_enable,
                    output busy_res, output done_res, output rx_byte, output ack_error,
                    input ready);
    modport sink   (input valid, input scl_level, input sda_level, input sda_enable,
                    input busy_res, input done_res, input rx_byte, input ack_error,
                    output ready);
endinterface

// ----- sv/i2cm_apb_regs.sv -----
// apb configuration registers: half period and ack timeout
module i2cm_apb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output i2cm_pkg::t_cfg     o_cfg
);
    logic [7:0] r_half_period;
    logic [7:0] r_ack_timeout;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;

    // register writes, word index taken from the upper address bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cm_pkg::HALF_PERIOD_RESET;
            r_ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RESET;
        end else if (w_write) begin
            unique case (paddr[2])
                i2cm_pkg::REG_HALF_PERIOD: r_half_period <= pwdata[7:0];
                i2cm_pkg::REG_ACK_TIMEOUT: r_ack_timeout <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            i2cm_pkg::REG_HALF_PERIOD: prdata = {24'd0, r_half_period};
            i2cm_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, r_ack_timeout};
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg.half_period_ticks = r_half_period;
    assign o_cfg.ack_timeout       = r_ack_timeout;
endmodule

// ----- sv/i2cm_core.sv -----
// bit engine state and the single-tick next-state logic
module i2cm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_tx_byte,
    input  logic                i_send_ack,
    input  logic                i_sda_in,
    input  i2cm_pkg::t_cfg      i_cfg,
    output i2cm_pkg::t_result   o_res
);
    logic [3:0] r_phase, n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_tick_count, n_tick_count;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_wait_count, n_wait_count;
    logic       r_ack_choice, n_ack_choice;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic       r_sda_oe, n_sda_oe;
    logic       r_error, n_error;
    logic [7:0] r_rx, n_rx;

    logic       w_done;
    logic       w_enter;
    logic       w_finish;
    logic [8:0] w_hp;
    logic [8:0] w_tick_next;
    logic [8:0] w_wait_next;

    // zero half period counts as one tick
    assign w_hp        = (i_cfg.half_period_ticks == 8'd0) ? 9'd1
                                                           : {1'b0, i_cfg.half_period_ticks};
    assign w_tick_next = {1'b0, r_tick_count} + 9'd1;
    assign w_wait_next = {1'b0, r_wait_count} + 9'd1;

    // next state for one tick
    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_tick_count = r_tick_count;
        n_shift      = r_shift;
        n_wait_count = r_wait_count;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_oe     = r_sda_oe;
        n_error      = r_error;
        n_rx         = r_rx;
        w_enter      = 1'b0;
        w_finish     = 1'b0;
        w_done       = 1'b0;

        if (r_phase == i2cm_pkg::PH_IDLE) begin
            // idle: take a new command
            n_bit_count  = 4'd0;
            n_wait_count = 8'd0;
            unique case (i_cmd)
                i2cm_pkg::CMD_START: begin
                    n_phase = i2cm_pkg::PH_ST_HI;
                    w_enter = 1'b1;
                end
                i2cm_pkg::CMD_STOP: begin
                    n_phase = i2cm_pkg::PH_SP_LO;
                    w_enter = 1'b1;
                end
                i2cm_pkg::CMD_WRITE: begin
                    n_shift = i_tx_byte;
                    n_phase = i2cm_pkg::PH_WR_LO;
                    w_enter = 1'b1;
                end
                i2cm_pkg::CMD_READ: begin
                    n_ack_choice = i_send_ack;
                    n_shift      = 8'd0;
                    n_phase      = i2cm_pkg::PH_RD_LO;
                    w_enter      = 1'b1;
                end
                default: ;
            endcase
        end else if (r_phase == i2cm_pkg::PH_AK_WAIT) begin
            // poll for acknowledge while scl is high
            if (!i_sda_in) begin
                n_scl    = 1'b0;
                n_error  = 1'b0;
                w_finish = 1'b1;
            end else if (w_wait_next > {1'b0, i_cfg.ack_timeout}) begin
                n_error      = 1'b1;
                n_wait_count = 8'd0;
                n_bit_count  = 4'd0;
                n_phase      = i2cm_pkg::PH_SP_LO;
                w_enter      = 1'b1;
            end else begin
                n_wait_count = w_wait_next[7:0];
            end
        end else begin
            // timed phases: sample on the last high tick of a read bit
            if (r_phase == i2cm_pkg::PH_RD_HI && w_tick_next >= w_hp) begin
                n_shift = {r_shift[6:0], i_sda_in};
            end
            n_tick_count = w_tick_next[7:0];
            if (w_tick_next >= w_hp) begin
                unique case (r_phase)
                    i2cm_pkg::PH_ST_HI: begin
                        n_phase = i2cm_pkg::PH_ST_LO;
                        w_enter = 1'b1;
                    end
                    i2cm_pkg::PH_ST_LO: begin
                        n_scl    = 1'b0;
                        w_finish = 1'b1;
                    end
                    i2cm_pkg::PH_SP_LO: begin
                        n_phase = i2cm_pkg::PH_SP_HI;
                        w_enter = 1'b1;
                    end
                    i2cm_pkg::PH_SP_HI: begin
                        n_sda    = 1'b1;
                        w_finish = 1'b1;
                    end
                    i2cm_pkg::PH_WR_LO: begin
                        n_phase = i2cm_pkg::PH_WR_HI;
                        w_enter = 1'b1;
                    end
                    i2cm_pkg::PH_WR_HI: begin
                        n_shift     = {r_shift[6:0], 1'b0};
                        n_bit_count = r_bit_count + 4'd1;
                        n_phase     = (n_bit_count >= i2cm_pkg::BITS_PER_BYTE)
                                      ? i2cm_pkg::PH_AK_LO : i2cm_pkg::PH_WR_LO;
                        w_enter     = 1'b1;
                    end
                    i2cm_pkg::PH_AK_LO: begin
                        n_phase = i2cm_pkg::PH_AK_HI;
                        w_enter = 1'b1;
                    end
                    i2cm_pkg::PH_AK_HI: begin
                        n_wait_count = 8'd0;
                        n_phase      = i2cm_pkg::PH_AK_WAIT;
                        w_enter      = 1'b1;
                    end
                    i2cm_pkg::PH_RD_LO: begin
                        n_phase = i2cm_pkg::PH_RD_HI;
                        w_enter = 1'b1;
                    end
                    i2cm_pkg::PH_RD_HI: begin
                        n_bit_count = r_bit_count + 4'd1;
                        if (n_bit_count >= i2cm_pkg::BITS_PER_BYTE) begin
                            n_rx    = n_shift;
                            n_phase = i2cm_pkg::PH_RA_LO;
                        end else begin
                            n_phase = i2cm_pkg::PH_RD_LO;
                        end
                        w_enter = 1'b1;
                    end
                    i2cm_pkg::PH_RA_LO: begin
                        n_phase = i2cm_pkg::PH_RA_HI;
                        w_enter = 1'b1;
                    end
                    i2cm_pkg::PH_RA_HI: begin
                        n_scl    = 1'b0;
                        w_finish = 1'b1;
                    end
                    default: begin
                        n_phase      = i2cm_pkg::PH_IDLE;
                        n_tick_count = 8'd0;
                    end
                endcase
            end
        end

        // command complete
        if (w_finish) begin
            n_phase      = i2cm_pkg::PH_IDLE;
            n_tick_count = 8'd0;
            n_bit_count  = 4'd0;
            n_wait_count = 8'd0;
            w_done       = 1'b1;
        end

        // line levels on entry to a phase
        if (w_enter) begin
            n_tick_count = 8'd0;
            unique case (n_phase)
                i2cm_pkg::PH_ST_HI: begin
                    n_scl    = 1'b1;
                    n_sda    = 1'b1;
                    n_sda_oe = 1'b1;
                end
                i2cm_pkg::PH_ST_LO: n_sda = 1'b0;
                i2cm_pkg::PH_SP_LO: begin
                    n_scl    = 1'b0;
                    n_sda    = 1'b0;
                    n_sda_oe = 1'b1;
                end
                i2cm_pkg::PH_WR_LO: begin
                    n_scl    = 1'b0;
                    n_sda_oe = 1'b1;
                    n_sda    = n_shift[7];
                end
                i2cm_pkg::PH_AK_LO, i2cm_pkg::PH_RD_LO: begin
                    n_scl    = 1'b0;
                    n_sda_oe = 1'b0;
                    n_sda    = 1'b1;
                end
                i2cm_pkg::PH_RA_LO: begin
                    n_scl    = 1'b0;
                    n_sda_oe = 1'b1;
                    n_sda    = !n_ack_choice;
                end
                i2cm_pkg::PH_SP_HI, i2cm_pkg::PH_WR_HI, i2cm_pkg::PH_AK_HI,
                i2cm_pkg::PH_AK_WAIT, i2cm_pkg::PH_RD_HI, i2cm_pkg::PH_RA_HI:
                    n_scl = 1'b1;
                default: ;
            endcase
        end
    end

    // state registers, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cm_pkg::PH_IDLE;
            r_bit_count  <= 4'd0;
            r_tick_count <= 8'd0;
            r_shift      <= 8'd0;
            r_wait_count <= 8'd0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_sda_oe     <= 1'b1;
            r_error      <= 1'b0;
            r_rx         <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_tick_count <= n_tick_count;
            r_shift      <= n_shift;
            r_wait_count <= n_wait_count;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_sda_oe     <= n_sda_oe;
            r_error      <= n_error;
            r_rx         <= n_rx;
        end
    end

    // result of this tick
    assign o_res.scl_level  = n_scl;
    assign o_res.sda_level  = n_sda;
    assign o_res.sda_enable = n_sda_oe;
    assign o_res.busy_res   = (n_phase != i2cm_pkg::PH_IDLE);
    assign o_res.done_res   = w_done;
    assign o_res.rx_byte    = n_rx;
    assign o_res.ack_error  = n_error;

    // counters are cleared whenever the engine rests
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == i2cm_pkg::PH_IDLE) |-> (r_bit_count == 4'd0 && r_wait_count == 8'd0))
        else $error("idle engine holds a stale bit or wait count");

    // ack polling keeps scl high with sda released
    a_ack_wait_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == i2cm_pkg::PH_AK_WAIT) |-> (r_scl && !r_sda_oe))
        else $error("ack wait with scl low or sda driven");

    // a low ack sample ends the write without error
    a_ack_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == i2cm_pkg::PH_AK_WAIT && !i_sda_in)
        |=> (r_phase == i2cm_pkg::PH_IDLE && !r_error && !r_scl))
        else $error("acknowledged write did not complete cleanly");

    // bit count stays within one byte
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= i2cm_pkg::BITS_PER_BYTE)
        else $error("bit count ran past one byte");
endmodule

// ----- sv/i2c_master_bit_engine.sv -----
// top level of the i2c master bit engine: apb registers, engine core and result register
//
// Usage: every request on i_in is one timing tick. It carries a command
// (none, start, stop, write byte, read byte), the byte to write, the ack
// choice for reads and the sampled sda level. Commands are ignored while a
// command is in progress. Each tick yields exactly one result on o_out:
// scl and sda drive levels, sda output enable, busy, a done pulse, the last
// received byte and the ack error flag, all showing the state after the tick.
// The result is registered: a tick accepted at one edge shows its result from
// the next cycle. Throughput is one tick per cycle while results are taken,
// with combinational next-state logic between engine state and result register.
// When the receiver stalls, the result waits in the result register and a
// new tick is accepted only in the cycle in which that result is taken.
// Reset (synchronous, active low) releases the bus with scl and sda high,
// empties the result register, and loads half period 2 and ack timeout 250.
// Registers: half_period_ticks at byte address 0, ack_timeout at 4.
module i2c_master_bit_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cm_in_if.sink      i_in,
    i2cm_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    i2cm_pkg::t_cfg    w_cfg;
    i2cm_pkg::t_result w_res;
    i2cm_pkg::t_result r_res;
    logic              r_out_valid;
    logic              w_accept;

    i2cm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // accept a tick whenever the result register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    i2cm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_accept),
        .i_cmd      (i_in.cmd),
        .i_tx_byte  (i_in.tx_byte),
        .i_send_ack (i_in.send_ack),
        .i_sda_in   (i_in.sda_in),
        .i_cfg      (w_cfg),
        .o_res      (w_res)
    );

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.scl_level  = r_res.scl_level;
    assign o_out.sda_level  = r_res.sda_level;
    assign o_out.sda_enable = r_res.sda_enable;
    assign o_out.busy_res   = r_res.busy_res;
    assign o_out.done_res   = r_res.done_res;
    assign o_out.rx_byte    = r_res.rx_byte;
    assign o_out.ack_error  = r_res.ack_error;

    // a pending result is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("tick accepted while a result is stalled");

    // every accepted tick shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted tick produced no result");

    // done pulse never comes with busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.done_res) |-> !r_res.busy_res)
        else $error("done reported while still busy");
endmodule
